### hdl/tphm_pkg.sv
// Shared types and constants for the timestamped pose history match block.
package tphm_pkg;

    localparam int STAMP_W = 32;
    localparam int ANGLE_W = 15;
    localparam int LIMIT_W = 11;
    localparam int OCC_W   = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1000;

    // Operation codes carried on the input tuser bit
    localparam logic OP_SAVE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One stored sample
    typedef struct packed {
        logic        [STAMP_W-1:0] stamp;
        logic signed [ANGLE_W-1:0] pan;
        logic signed [ANGLE_W-1:0] tilt;
    } sample_t;

    // One accepted input item
    typedef struct packed {
        logic                      operation;
        logic        [STAMP_W-1:0] stamp;
        logic signed [ANGLE_W-1:0] pan_in;
        logic signed [ANGLE_W-1:0] tilt_in;
    } request_t;

    // One result item
    typedef struct packed {
        logic                      found;
        logic signed [ANGLE_W-1:0] pan_out;
        logic signed [ANGLE_W-1:0] tilt_out;
        logic        [STAMP_W-1:0] matched_stamp;
        logic        [OCC_W-1:0]   occupancy;
    } result_t;

endpackage

### hdl/tphm_engine.sv
// Sample memory, FIFO pointers and the save/query sequencer.
module tphm_engine #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tphm_pkg::LIMIT_W-1:0]  history_limit,
    input  logic                          start,
    input  tphm_pkg::request_t            request,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output tphm_pkg::result_t             result
);
    import tphm_pkg::*;

    localparam int PW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAVE,
        ST_QREAD,
        ST_QEVAL,
        ST_DONE
    } state_t;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    state_t               state_reg;
    request_t             req_reg;
    logic [PW-1:0]        oldest_reg;
    logic [PW-1:0]        newest_reg;
    logic [CW-1:0]        count_reg;
    logic                 first_reg;
    sample_t              best_reg;
    logic [STAMP_W-1:0]   best_diff_reg;
    result_t              result_reg;

    sample_t              mem [HISTORY_DEPTH];
    sample_t              rd_data_reg;
    logic [PW-1:0]        rd_addr;

    // Save path: drop for a full store, append, drop for the limit
    logic                 full_drop;
    logic [PW-1:0]        oldest_a;
    logic [CW-1:0]        count_a;
    logic [CW-1:0]        count_b;
    logic                 limit_drop;
    logic [PW-1:0]        oldest_save_next;
    logic [CW-1:0]        count_save_next;
    logic [CMPW-1:0]      count_b_ext;
    logic [CMPW-1:0]      limit_ext;
    logic [CMPW-1:0]      count_save_ext;
    logic [CMPW-1:0]      count_ext;
    logic [CMPW-1:0]      count_dec_ext;

    // Query path
    logic [STAMP_W-1:0]   diff;
    logic                 take;
    logic [CW-1:0]        count_dec;

    always_comb
    begin
        full_drop        = (count_reg >= FULL_CNT);
        oldest_a         = full_drop ? next_slot(oldest_reg) : oldest_reg;
        count_a          = full_drop ? count_reg - 1'b1 : count_reg;
        count_b          = count_a + 1'b1;
        count_b_ext      = CMPW'(count_b);
        limit_ext        = CMPW'(history_limit);
        limit_drop       = (count_b_ext > limit_ext);
        oldest_save_next = limit_drop ? next_slot(oldest_a) : oldest_a;
        count_save_next  = limit_drop ? count_b - 1'b1 : count_b;
        count_save_ext   = CMPW'(count_save_next);
        count_ext        = CMPW'(count_reg);
        count_dec        = count_reg - 1'b1;
        count_dec_ext    = CMPW'(count_dec);
    end

    // Absolute time distance of the front sample to the query
    always_comb
    begin
        diff = (rd_data_reg.stamp > req_reg.stamp) ? rd_data_reg.stamp - req_reg.stamp
                                                    : req_reg.stamp - rd_data_reg.stamp;
        take = first_reg || (diff <= best_diff_reg);
    end

    // Read the front in QREAD, prefetch the slot behind it in QEVAL
    assign rd_addr = (state_reg == ST_QEVAL) ? next_slot(oldest_reg) : oldest_reg;

    // Sample memory: written on save, read during a query walk
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SAVE)
        begin
            mem[newest_reg] <= '{stamp: req_reg.stamp, pan: req_reg.pan_in,
                                 tilt: req_reg.tilt_in};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer, pointers and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b0;
            req_reg       <= '0;
            best_reg      <= '0;
            best_diff_reg <= '0;
            result_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= request;
                        if (request.operation == OP_SAVE)
                        begin
                            state_reg <= ST_SAVE;
                        end
                        else if (count_reg == '0)
                        begin
                            result_reg <= '0;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_QREAD;
                        end
                    end
                end
                ST_SAVE:
                begin
                    oldest_reg <= oldest_save_next;
                    newest_reg <= next_slot(newest_reg);
                    count_reg  <= count_save_next;
                    result_reg <= '{found: 1'b0, pan_out: '0, tilt_out: '0,
                                    matched_stamp: '0,
                                    occupancy: count_save_ext[OCC_W-1:0]};
                    state_reg  <= ST_DONE;
                end
                ST_QREAD:
                begin
                    first_reg <= 1'b1;
                    state_reg <= ST_QEVAL;
                end
                ST_QEVAL:
                begin
                    first_reg <= 1'b0;
                    if (take)
                    begin
                        // Pop the front; it becomes the best match
                        best_reg      <= rd_data_reg;
                        best_diff_reg <= diff;
                        oldest_reg    <= next_slot(oldest_reg);
                        count_reg     <= count_dec;
                        if (count_dec == '0)
                        begin
                            result_reg <= '{found: 1'b1, pan_out: rd_data_reg.pan,
                                            tilt_out: rd_data_reg.tilt,
                                            matched_stamp: rd_data_reg.stamp,
                                            occupancy: count_dec_ext[OCC_W-1:0]};
                            state_reg  <= ST_DONE;
                        end
                    end
                    else
                    begin
                        result_reg <= '{found: 1'b1, pan_out: best_reg.pan,
                                        tilt_out: best_reg.tilt,
                                        matched_stamp: best_reg.stamp,
                                        occupancy: count_ext[OCC_W-1:0]};
                        state_reg  <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign result    = result_reg;

    // Count never exceeds the store depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("sample count above store depth");

    // A save reaches DONE in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SAVE |=> state_reg == ST_DONE)
        else $error("save did not complete");

    // The walk only evaluates while samples remain
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_QEVAL |-> count_reg != '0)
        else $error("query walk on empty history");

    // A waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_reg))
        else $error("pending result changed");

    // Pointers stay consistent with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> oldest_reg == newest_reg)
        else $error("empty history with unequal pointers");

endmodule

### hdl/timestamped_pose_history_match.sv
// Top level: stream ports, limit register and output register around the engine.
// A save passes through the SAVE and DONE states. A query reads the front (QREAD), then
// walks the history one sample per cycle (QEVAL), popping each sample no farther from the
// query stamp than the best so far; an empty query goes straight to DONE. One transaction
// at a time: no new item is accepted until the output register takes the result.
// Reset: rst_n is asynchronous, active low; it empties the history, sets the
// limit to 1000 and clears the output; memory contents are not cleared.
module timestamped_pose_history_match #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // stamp[31:0], pan_in[46:32], tilt_in[61:47]
    input  logic [0:0]  s_axis_tuser,  // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // pan_out[14:0], tilt_out[29:15],
                                       // matched_stamp[61:30], occupancy[72:62]
    output logic [0:0]  m_axis_tuser   // found[0]
);
    import tphm_pkg::*;

    logic [LIMIT_W-1:0] history_limit_reg;
    request_t           request;
    logic               engine_idle;
    logic               res_valid;
    logic               res_ready;
    result_t            engine_result;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               start;

    // Hold the history limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            history_limit_reg <= cfg_wr_data;
        end
    end

    // Unpack the input transaction
    always_comb
    begin
        request.operation = s_axis_tuser[0];
        request.stamp     = s_axis_tdata[31:0];
        request.pan_in    = s_axis_tdata[46:32];
        request.tilt_in   = s_axis_tdata[61:47];
    end

    assign s_axis_tready = engine_idle;
    assign start         = s_axis_tvalid && engine_idle;

    tphm_engine #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .history_limit (history_limit_reg),
        .start         (start),
        .request       (request),
        .idle          (engine_idle),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result        (engine_result)
    );

    // Output register: load a finished result when the slot is free or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= engine_result;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.found;
    assign m_axis_tdata  = {7'd0, out_reg.occupancy, out_reg.matched_stamp,
                            out_reg.tilt_out, out_reg.pan_out};

endmodule
